FILE: design/top_of_book_microprice_features_assert.svh
// ----------------------------------------------------------------------------
// top_of_book_microprice_features_assert.svh
// assertion macros used by the checker file tobmp_checker
// ----------------------------------------------------------------------------
`ifndef TOP_OF_BOOK_MICROPRICE_FEATURES_ASSERT_SVH
`define TOP_OF_BOOK_MICROPRICE_FEATURES_ASSERT_SVH

// consequent checked in the same cycle
`define TOBMP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define TOBMP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/tobmp_pkg.sv
// ----------------------------------------------------------------------------
// tobmp_pkg
// shared widths and status codes of the top-of-book feature pipeline
// ----------------------------------------------------------------------------
package tobmp_pkg;

    localparam int PRICE_BITS_DEF = 32;
    localparam int SIZE_BITS_DEF  = 32;
    localparam int FRAC_BITS_DEF  = 16;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_CROSSED = 2'd1,
        STATUS_EMPTY   = 2'd2
    } t_book_status;

endpackage

FILE: design/tobmp_div_stage.sv
// ----------------------------------------------------------------------------
// tobmp_div_stage
// one restoring division step for the microprice and imbalance lanes,
// both divided by the same total size
// ----------------------------------------------------------------------------
module tobmp_div_stage #(
    parameter int TW = tobmp_pkg::SIZE_BITS_DEF + 1,
    parameter int QW = tobmp_pkg::PRICE_BITS_DEF + tobmp_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [TW-1:0] i_div,
    input  logic [TW-1:0] i_rem_m,
    input  logic [QW-1:0] i_acc_m,
    input  logic [TW-1:0] i_rem_i,
    input  logic [QW-1:0] i_acc_i,
    output logic [TW-1:0] o_rem_m,
    output logic [QW-1:0] o_acc_m,
    output logic [TW-1:0] o_rem_i,
    output logic [QW-1:0] o_acc_i
);

    logic [TW:0]   w_sh_m;
    logic [TW:0]   w_sh_i;
    logic [TW:0]   w_df_m;
    logic [TW:0]   w_df_i;
    logic          w_ge_m;
    logic          w_ge_i;
    logic [TW-1:0] r_rem_m;
    logic [QW-1:0] r_acc_m;
    logic [TW-1:0] r_rem_i;
    logic [QW-1:0] r_acc_i;

    always_comb begin
        w_sh_m = {i_rem_m, i_acc_m[QW-1]};
        w_sh_i = {i_rem_i, i_acc_i[QW-1]};
        w_df_m = w_sh_m - {1'b0, i_div};
        w_df_i = w_sh_i - {1'b0, i_div};
        w_ge_m = w_sh_m >= {1'b0, i_div};
        w_ge_i = w_sh_i >= {1'b0, i_div};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem_m <= w_ge_m ? w_df_m[TW-1:0] : w_sh_m[TW-1:0];
            r_rem_i <= w_ge_i ? w_df_i[TW-1:0] : w_sh_i[TW-1:0];
            r_acc_m <= {i_acc_m[QW-2:0], w_ge_m};
            r_acc_i <= {i_acc_i[QW-2:0], w_ge_i};
        end
    end

    assign o_rem_m = r_rem_m;
    assign o_acc_m = r_acc_m;
    assign o_rem_i = r_rem_i;
    assign o_acc_i = r_acc_i;

endmodule

FILE: design/top_of_book_microprice_features.sv
// ----------------------------------------------------------------------------
// top_of_book_microprice_features
// microprice, imbalance, spread and doubled mid of one top-of-book update
//
// input channel: i_valid / o_stall with bid and ask price and size; output
// channel: o_valid / i_stall with status and the four features. an item is
// taken at an edge with valid high and stall low.
// the pipeline from accept to o_valid: one stage of partial products and
// book checks, one stage summing the cross products, one division stage per
// quotient bit, and an output register. throughput: one item per cycle while
// i_stall lets the output drain, set by the fully pipelined divider that
// shares one total-size divisor for both quotients.
// the whole pipeline advances together whenever the output register is
// empty or being taken; o_stall rises only while a result waits under
// i_stall, so nothing is dropped or repeated.
// crossed or empty books give zero features with their status code.
// reset (synchronous, active low) clears all valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module top_of_book_microprice_features #(
    parameter int PRICE_BITS = tobmp_pkg::PRICE_BITS_DEF,
    parameter int SIZE_BITS  = tobmp_pkg::SIZE_BITS_DEF,
    parameter int FRAC_BITS  = tobmp_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [PRICE_BITS-1:0]           i_bid_price,
    input  logic [SIZE_BITS-1:0]            i_bid_size,
    input  logic [PRICE_BITS-1:0]           i_ask_price,
    input  logic [SIZE_BITS-1:0]            i_ask_size,
    output logic                            o_valid,
    input  logic                            i_stall,
    output tobmp_pkg::t_book_status         o_book_status,
    output logic [PRICE_BITS:0]             o_mid_price_doubled,
    output logic [PRICE_BITS-1:0]           o_spread_ticks,
    output logic signed [FRAC_BITS+1:0]     o_imbalance_q16,
    output logic [PRICE_BITS+FRAC_BITS-1:0] o_microprice_q16
);

    localparam int TW  = SIZE_BITS + 1;
    localparam int QW  = PRICE_BITS + FRAC_BITS;
    localparam int SL  = SIZE_BITS / 2;
    localparam int SH  = SIZE_BITS - SL;
    localparam int NSW = PRICE_BITS + SIZE_BITS + 1;
    localparam int NW  = NSW + FRAC_BITS;
    localparam int IW  = FRAC_BITS + 2;

    logic w_en;

    // stage 1 inputs
    logic                    w_crossed;
    logic [TW-1:0]           w_total;
    logic                    w_neg;
    logic [SIZE_BITS-1:0]    w_mag;
    tobmp_pkg::t_book_status w_status;

    logic [QW:0]             r_vld;
    logic                    r1_vld;
    tobmp_pkg::t_book_status r1_status;
    logic [PRICE_BITS:0]     r1_mid;
    logic [PRICE_BITS-1:0]   r1_spread;
    logic [TW-1:0]           r1_total;
    logic                    r1_neg;
    logic [SIZE_BITS-1:0]    r1_mag;
    logic [PRICE_BITS+SL-1:0] r1_pa_lo;
    logic [PRICE_BITS+SH-1:0] r1_pa_hi;
    logic [PRICE_BITS+SL-1:0] r1_pb_lo;
    logic [PRICE_BITS+SH-1:0] r1_pb_hi;

    // stage 2
    logic [PRICE_BITS+SH:0]  w_sum_hi;
    logic [PRICE_BITS+SL:0]  w_sum_lo;
    logic [NSW-1:0]          w_cross;
    logic [NW-1:0]           w_num_m;
    logic [NW-1:0]           w_num_i;
    logic [TW-1:0]           r2_rem_m;
    logic [QW-1:0]           r2_acc_m;
    logic [TW-1:0]           r2_rem_i;
    logic [QW-1:0]           r2_acc_i;

    // side payload alongside the divider
    tobmp_pkg::t_book_status r_status [0:QW];
    logic [PRICE_BITS:0]     r_mid    [0:QW];
    logic [PRICE_BITS-1:0]   r_spread [0:QW];
    logic                    r_neg    [0:QW];
    logic [TW-1:0]           r_div    [0:QW];

    wire  [TW-1:0]           s_rem_m  [0:QW];
    wire  [QW-1:0]           s_acc_m  [0:QW];
    wire  [TW-1:0]           s_rem_i  [0:QW];
    wire  [QW-1:0]           s_acc_i  [0:QW];

    // output register
    logic                    r_out_vld;
    tobmp_pkg::t_book_status r_out_status;
    logic [PRICE_BITS:0]     r_out_mid;
    logic [PRICE_BITS-1:0]   r_out_spread;
    logic [IW-1:0]           r_out_imb;
    logic [QW-1:0]           r_out_micro;
    logic [IW-1:0]           w_q_i;
    logic [IW-1:0]           w_imb;
    logic                    w_ok;

    assign w_en    = !r_out_vld || !i_stall;
    assign o_stall = !w_en;

    always_comb begin
        w_crossed = i_bid_price >= i_ask_price;
        w_total   = {1'b0, i_bid_size} + {1'b0, i_ask_size};
        w_neg     = i_ask_size > i_bid_size;
        w_mag     = w_neg ? (i_ask_size - i_bid_size) : (i_bid_size - i_ask_size);
        if (w_crossed) begin
            w_status = tobmp_pkg::STATUS_CROSSED;
        end else if (w_total == '0) begin
            w_status = tobmp_pkg::STATUS_EMPTY;
        end else begin
            w_status = tobmp_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r_vld  <= '0;
        end else if (w_en) begin
            r1_vld <= i_valid;
            r_vld  <= {r_vld[QW-1:0], r1_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_status <= w_status;
            r1_mid    <= {1'b0, i_bid_price} + {1'b0, i_ask_price};
            r1_spread <= i_ask_price - i_bid_price;
            r1_total  <= w_total;
            r1_neg    <= w_neg;
            r1_mag    <= w_mag;
            r1_pa_lo  <= {{SL{1'b0}}, i_ask_price} * {{PRICE_BITS{1'b0}}, i_bid_size[SL-1:0]};
            r1_pa_hi  <= {{SH{1'b0}}, i_ask_price}
                         * {{PRICE_BITS{1'b0}}, i_bid_size[SIZE_BITS-1:SL]};
            r1_pb_lo  <= {{SL{1'b0}}, i_bid_price} * {{PRICE_BITS{1'b0}}, i_ask_size[SL-1:0]};
            r1_pb_hi  <= {{SH{1'b0}}, i_bid_price}
                         * {{PRICE_BITS{1'b0}}, i_ask_size[SIZE_BITS-1:SL]};
        end
    end

    always_comb begin
        w_sum_hi = {1'b0, r1_pa_hi} + {1'b0, r1_pb_hi};
        w_sum_lo = {1'b0, r1_pa_lo} + {1'b0, r1_pb_lo};
        w_cross  = {w_sum_hi, {SL{1'b0}}} + {{SH{1'b0}}, w_sum_lo};
        w_num_m  = {w_cross, {FRAC_BITS{1'b0}}};
        w_num_i  = {{(PRICE_BITS + 1){1'b0}}, r1_mag, {FRAC_BITS{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_rem_m <= w_num_m[NW-1:QW];
            r2_acc_m <= w_num_m[QW-1:0];
            r2_rem_i <= w_num_i[NW-1:QW];
            r2_acc_i <= w_num_i[QW-1:0];
            for (int k = QW; k >= 1; k--) begin
                r_status[k] <= r_status[k-1];
                r_mid[k]    <= r_mid[k-1];
                r_spread[k] <= r_spread[k-1];
                r_neg[k]    <= r_neg[k-1];
                r_div[k]    <= r_div[k-1];
            end
            r_status[0] <= r1_status;
            r_mid[0]    <= r1_mid;
            r_spread[0] <= r1_spread;
            r_neg[0]    <= r1_neg;
            r_div[0]    <= r1_total;
        end
    end

    assign s_rem_m[0] = r2_rem_m;
    assign s_acc_m[0] = r2_acc_m;
    assign s_rem_i[0] = r2_rem_i;
    assign s_acc_i[0] = r2_acc_i;

    for (genvar g = 0; g < QW; g++) begin : g_div
        tobmp_div_stage #(
            .TW(TW),
            .QW(QW)
        ) u_stage (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_div   (r_div[g]),
            .i_rem_m (s_rem_m[g]),
            .i_acc_m (s_acc_m[g]),
            .i_rem_i (s_rem_i[g]),
            .i_acc_i (s_acc_i[g]),
            .o_rem_m (s_rem_m[g+1]),
            .o_acc_m (s_acc_m[g+1]),
            .o_rem_i (s_rem_i[g+1]),
            .o_acc_i (s_acc_i[g+1])
        );
    end

    always_comb begin
        w_ok  = r_status[QW] == tobmp_pkg::STATUS_OK;
        w_q_i = s_acc_i[QW][IW-1:0];
        w_imb = r_neg[QW] ? ({IW{1'b0}} - w_q_i) : w_q_i;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_vld[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_status <= r_status[QW];
            r_out_mid    <= w_ok ? r_mid[QW] : '0;
            r_out_spread <= w_ok ? r_spread[QW] : '0;
            r_out_imb    <= w_ok ? w_imb : '0;
            r_out_micro  <= w_ok ? s_acc_m[QW] : '0;
        end
    end

    assign o_valid             = r_out_vld;
    assign o_book_status       = r_out_status;
    assign o_mid_price_doubled = r_out_mid;
    assign o_spread_ticks      = r_out_spread;
    assign o_imbalance_q16     = $signed(r_out_imb);
    assign o_microprice_q16    = r_out_micro;

endmodule

FILE: design/tobmp_checker.sv
// ----------------------------------------------------------------------------
// tobmp_checker
// port-level checks of the top-of-book feature block, bound to the top level
// ----------------------------------------------------------------------------
`include "top_of_book_microprice_features_assert.svh"

module tobmp_checker #(
    parameter int PRICE_BITS = tobmp_pkg::PRICE_BITS_DEF,
    parameter int FRAC_BITS  = tobmp_pkg::FRAC_BITS_DEF
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_stall,
    input logic                            o_valid,
    input logic                            i_stall,
    input tobmp_pkg::t_book_status         o_book_status,
    input logic [PRICE_BITS:0]             o_mid_price_doubled,
    input logic [PRICE_BITS-1:0]           o_spread_ticks,
    input logic signed [FRAC_BITS+1:0]     o_imbalance_q16,
    input logic [PRICE_BITS+FRAC_BITS-1:0] o_microprice_q16
);

    localparam logic signed [FRAC_BITS+1:0] IMB_ONE = (FRAC_BITS + 2)'(1) << FRAC_BITS;
    localparam logic signed [FRAC_BITS+1:0] IMB_NEG = -IMB_ONE;

    logic w_ok;
    logic w_bad;
    logic w_zero;
    logic w_imb_in;

    always_comb begin
        w_ok     = o_valid && (o_book_status == tobmp_pkg::STATUS_OK);
        w_bad    = o_valid && (o_book_status != tobmp_pkg::STATUS_OK);
        w_zero   = (o_mid_price_doubled == '0) && (o_spread_ticks == '0)
                   && (o_imbalance_q16 == '0) && (o_microprice_q16 == '0);
        w_imb_in = (o_imbalance_q16 <= IMB_ONE) && (o_imbalance_q16 >= IMB_NEG);
    end

    `TOBMP_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid, "result dropped under stall")
    `TOBMP_ASSERT_SAME(a_stall_src, 1'b1, o_stall == (o_valid && i_stall), "bad input stall")
    `TOBMP_ASSERT_SAME(a_bad_zero, w_bad, w_zero, "nonzero features on bad book")
    `TOBMP_ASSERT_SAME(a_ok_spread, w_ok, o_spread_ticks != '0, "zero spread on sound book")
    `TOBMP_ASSERT_SAME(a_imb_range, w_ok, w_imb_in, "imbalance out of range")

endmodule

bind top_of_book_microprice_features tobmp_checker #(
    .PRICE_BITS(PRICE_BITS),
    .FRAC_BITS (FRAC_BITS)
) u_tobmp_checker (.*);
